@@ rtl/mtsr_pkg.sv @@
`default_nettype none

package mtsr_pkg;

  // Input word: one element, or a close marker, for one of the two runs
  typedef struct packed {
    logic               run_select;
    logic               has_value;
    logic signed [31:0] value;
    logic               last_of_run;
  } in_word_t;

  // Output word: one element of the merged sequence
  typedef struct packed {
    logic signed [31:0] value_res;
    logic               from_second;
    logic               last;
    logic               overflow;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/merge_two_sorted_runs_core.sv @@
// Two-way merge of two ascending runs of signed 32-bit values.
// Input channel (in_valid_i / in_stall_o / in_data_i): each word goes to run 0
// or run 1 and is written into that run's memory. One word is taken per
// cycle while loading. A word with last_of_run closes its run; a word without
// a value only closes it. Words sent to a run that is already closed are
// dropped, and values beyond RUN_DEPTH per run are dropped and flagged.
// Once both runs are closed, in_stall_o stays high for the whole merge.
// Output channel (out_valid_o / out_stall_i / out_data_o): the stable merged
// sequence, ties taken from run 0 first, with the final word marked last.
// After the closing word is taken, the block passes through StPrime, where
// both run heads are read from memory, and then loads the first result into
// the output register in StMerge. After that, one result per cycle leaves
// while out_stall_i is low. The head memories are read at the next indices,
// which keeps this pace. A stall holds the output register and freezes the
// merge walk. After the final result the block takes new words at once, even
// while that result waits in the output register. Two empty runs give no
// results. Reset clears counts, close flags and the overflow flag; memory
// contents are left as they are.
`default_nettype none

module merge_two_sorted_runs_core #(
  parameter int RUN_DEPTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mtsr_pkg::in_word_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mtsr_pkg::out_word_t    out_data_o
);

  localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(RUN_DEPTH);

  typedef enum logic [1:0] {
    StLoad,
    StPrime,
    StMerge
  } state_e;

  state_e state_q;

  logic [CW-1:0] first_cnt_q, second_cnt_q;
  logic [CW-1:0] i_q, j_q;
  logic [CW-1:0] i_d, j_d;
  logic          first_closed_q, second_closed_q;
  logic          overflow_q;

  logic                out_valid_q;
  mtsr_pkg::out_word_t out_data_q;

  logic signed [31:0] first_mem  [RUN_DEPTH];
  logic signed [31:0] second_mem [RUN_DEPTH];
  logic signed [31:0] head_a_q, head_b_q;

  // Load-side decode
  logic          in_acc;
  logic          sel_closed;
  logic [CW-1:0] sel_cnt;
  logic          sel_full;
  logic          wr_first, wr_second;
  logic          drop_val;
  logic          close_first, close_second;

  // Merge-side decode
  logic          emit;
  logic          take_first;
  logic          is_last;

  assign in_stall_o = (state_q != StLoad);
  assign in_acc     = in_valid_i && (state_q == StLoad);
  assign sel_closed = in_data_i.run_select ? second_closed_q : first_closed_q;
  assign sel_cnt    = in_data_i.run_select ? second_cnt_q : first_cnt_q;
  assign sel_full   = (sel_cnt == DepthC);

  assign wr_first  = in_acc && !sel_closed && in_data_i.has_value && !sel_full &&
                     !in_data_i.run_select;
  assign wr_second = in_acc && !sel_closed && in_data_i.has_value && !sel_full &&
                     in_data_i.run_select;
  assign drop_val  = in_acc && !sel_closed && in_data_i.has_value && sel_full;

  assign close_first  = first_closed_q ||
                        (in_acc && !sel_closed && in_data_i.last_of_run &&
                         !in_data_i.run_select);
  assign close_second = second_closed_q ||
                        (in_acc && !sel_closed && in_data_i.last_of_run &&
                         in_data_i.run_select);

  // Pick the smaller head, run 0 on ties
  assign take_first = (i_q < first_cnt_q) &&
                      ((j_q >= second_cnt_q) || (head_a_q <= head_b_q));
  assign emit       = (state_q == StMerge) && (!out_valid_q || !out_stall_i);

  // Advance the walk; read addresses follow the next indices
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (emit) begin
      if (take_first) begin
        i_d = i_q + CW'(1);
      end else begin
        j_d = j_q + CW'(1);
      end
    end
  end

  assign is_last = (i_d == first_cnt_q) && (j_d == second_cnt_q);

  // Run memories: write while loading, read the heads every cycle
  always_ff @(posedge clk_i) begin
    if (wr_first) begin
      first_mem[first_cnt_q[AW-1:0]] <= in_data_i.value;
    end
    head_a_q <= first_mem[i_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_second) begin
      second_mem[second_cnt_q[AW-1:0]] <= in_data_i.value;
    end
    head_b_q <= second_mem[j_d[AW-1:0]];
  end

  // Control, counts and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StLoad;
      first_cnt_q     <= '0;
      second_cnt_q    <= '0;
      first_closed_q  <= 1'b0;
      second_closed_q <= 1'b0;
      overflow_q      <= 1'b0;
      i_q             <= '0;
      j_q             <= '0;
      out_valid_q     <= 1'b0;
      out_data_q      <= '0;
    end else begin
      // Load the output word on emit, drop it once taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StLoad: begin
          if (wr_first) begin
            first_cnt_q <= first_cnt_q + CW'(1);
          end
          if (wr_second) begin
            second_cnt_q <= second_cnt_q + CW'(1);
          end
          if (drop_val) begin
            overflow_q <= 1'b1;
          end
          first_closed_q  <= close_first;
          second_closed_q <= close_second;
          if (close_first && close_second) begin
            state_q <= StPrime;
          end
        end

        StPrime: begin
          // Heads at index zero are being read; skip the merge if both are empty
          if (first_cnt_q == '0 && second_cnt_q == '0) begin
            first_closed_q  <= 1'b0;
            second_closed_q <= 1'b0;
            overflow_q      <= 1'b0;
            state_q         <= StLoad;
          end else begin
            state_q <= StMerge;
          end
        end

        StMerge: begin
          if (emit) begin
            out_data_q.value_res   <= take_first ? head_a_q : head_b_q;
            out_data_q.from_second <= !take_first;
            out_data_q.last        <= is_last;
            out_data_q.overflow    <= overflow_q;
            if (is_last) begin
              // Clear for the next pair
              i_q             <= '0;
              j_q             <= '0;
              first_cnt_q     <= '0;
              second_cnt_q    <= '0;
              first_closed_q  <= 1'b0;
              second_closed_q <= 1'b0;
              overflow_q      <= 1'b0;
              state_q         <= StLoad;
            end else begin
              i_q <= i_d;
              j_q <= j_d;
            end
          end
        end

        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
